@@ sv/ppmfd_pkg.sv @@
// shared constants for the ppm frame decoder
package ppmfd_pkg;

  // field widths
  localparam int TICKS_W   = 32;
  localparam int DIV_W     = 8;
  localparam int US_W      = 16;
  localparam int FCH_W     = 4;
  localparam int CHIDX_W   = 3;
  localparam int BAD_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // largest frame that can be sent out
  localparam int RESULT_LIMIT = 8;

  // default buffer depth
  localparam int MAX_CHANNELS_DEF = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_US   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MIN_US    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN_US   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_CHANNELS = 2'd3;

  // register reset values
  localparam logic [DIV_W-1:0] TICKS_PER_US_RST   = 8'd84;
  localparam logic [US_W-1:0]  SYNC_MIN_US_RST    = 16'd2500;
  localparam logic [US_W-1:0]  PULSE_MIN_US_RST   = 16'd1050;
  localparam logic [FCH_W-1:0] FRAME_CHANNELS_RST = 4'd8;

endpackage

@@ sv/ppmfd_div.sv @@
// iterative restoring divider, one quotient bit per cycle
module ppmfd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ppmfd_pkg::TICKS_W-1:0] dividend,
  input  logic [ppmfd_pkg::DIV_W-1:0]   divisor,
  output logic                          done,
  output logic [ppmfd_pkg::US_W-1:0]    quotient
);
  import ppmfd_pkg::*;

  localparam int STEP_W = $clog2(TICKS_W);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [DIV_W-1:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]    dvs_r, dvs_nxt;
  logic [TICKS_W-1:0]  dvd_r, dvd_nxt;
  logic [DIV_W:0]      trial;
  logic [DIV_W:0]      diff;

  // shift in the next dividend bit and try the subtraction
  assign trial = {rem_r, dvd_r[TICKS_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    dvd_nxt  = dvd_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      dvd_nxt  = dividend;
    end else if (busy_r) begin
      // quotient bits enter at the bottom as dividend bits leave the top
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DIV_W-1:0];
        dvd_nxt = {dvd_r[TICKS_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_W-1:0];
        dvd_nxt = {dvd_r[TICKS_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(TICKS_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    dvd_r <= dvd_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r[US_W-1:0];

endmodule

@@ sv/ppm_frame_decoder.sv @@
// ppm frame decoder top level: sequencer, channel buffer and result register
//
// Each request carries one captured pulse interval in timer ticks. The block
// divides it by ticks_per_us in a shared bit-serial divider, then sorts the
// result against the sync and minimum-pulse thresholds; a request that does
// not end a frame stalls the input from acceptance until that sort is done.
// A sync interval that closes a good frame then sends out one result per
// stored channel, one per cycle while the output side takes them, with last
// set on the final channel; the next request is accepted once the final
// channel has been loaded into the output register. A frame with the wrong
// channel count, or with more pulses than the buffer holds, sends nothing and
// increments the wrapping bad-frame count that every result carries.
// Configuration is to be written only while the block is idle; the block does not enforce it.
module ppm_frame_decoder #(
  parameter int MAX_CHANNELS = ppmfd_pkg::MAX_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [ppmfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ppmfd_pkg::CFG_DAT_W-1:0] cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ppmfd_pkg::TICKS_W-1:0]   in_capture_ticks,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ppmfd_pkg::CHIDX_W-1:0]   out_channel_index,
  output logic [ppmfd_pkg::US_W-1:0]      out_pulse_us,
  output logic                            out_last,
  output logic [ppmfd_pkg::BAD_W-1:0]     out_bad_frames
);
  import ppmfd_pkg::*;

  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CMP_W = (CNT_W > FCH_W) ? CNT_W : FCH_W;

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [DIV_W-1:0]    ticks_per_us_r;
  logic [US_W-1:0]     sync_min_us_r;
  logic [US_W-1:0]     pulse_min_us_r;
  logic [FCH_W-1:0]    frame_channels_r;

  logic [US_W-1:0]     pulse_buf_r [MAX_CHANNELS];
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  logic [BAD_W-1:0]    bad_r, bad_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                buf_we;

  logic                out_valid_r, out_valid_nxt;
  logic [CHIDX_W-1:0]  out_idx_r;
  logic [US_W-1:0]     out_us_r;
  logic                out_last_r;
  logic [BAD_W-1:0]    out_bad_r;
  logic                out_load;

  logic                accept;
  logic                div_done;
  logic [DIV_W-1:0]    divisor;
  logic [US_W-1:0]     us;
  logic                good;
  logic                is_last;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  // a zero divisor acts as one
  assign divisor = (ticks_per_us_r == '0) ? DIV_W'(1) : ticks_per_us_r;

  ppmfd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (in_capture_ticks),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (us)
  );

  // frame check at a sync interval
  assign good = !ovf_r
             && (CMP_W'(count_r) == CMP_W'(frame_channels_r))
             && (CMP_W'(count_r) <= CMP_W'(RESULT_LIMIT));

  assign is_last  = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    bad_nxt   = bad_r;
    idx_nxt   = idx_r;
    buf_we    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = ST_IDLE;
        if (us >= sync_min_us_r) begin
          if (good && count_r != '0) begin
            idx_nxt   = '0;
            state_nxt = ST_EMIT;
          end else begin
            if (!good) bad_nxt = bad_r + BAD_W'(1);
            count_nxt = '0;
          end
          ovf_nxt = 1'b0;
        end else if (us >= pulse_min_us_r) begin
          if (count_r < CNT_W'(MAX_CHANNELS)) begin
            buf_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          if (is_last) begin
            count_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      count_r          <= '0;
      ovf_r            <= 1'b0;
      bad_r            <= '0;
      idx_r            <= '0;
      out_valid_r      <= 1'b0;
      ticks_per_us_r   <= TICKS_PER_US_RST;
      sync_min_us_r    <= SYNC_MIN_US_RST;
      pulse_min_us_r   <= PULSE_MIN_US_RST;
      frame_channels_r <= FRAME_CHANNELS_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      bad_r       <= bad_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TICKS_PER_US:   ticks_per_us_r   <= cfg_data[DIV_W-1:0];
          REG_SYNC_MIN_US:    sync_min_us_r    <= cfg_data[US_W-1:0];
          REG_PULSE_MIN_US:   pulse_min_us_r   <= cfg_data[US_W-1:0];
          REG_FRAME_CHANNELS: frame_channels_r <= cfg_data[FCH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // channel buffer and result payload
  always_ff @(posedge clk) begin
    if (buf_we) pulse_buf_r[count_r[IDX_W-1:0]] <= us;
    if (out_load) begin
      out_idx_r  <= CHIDX_W'(idx_r);
      out_us_r   <= pulse_buf_r[idx_r];
      out_last_r <= is_last;
      out_bad_r  <= bad_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel_index = out_idx_r;
  assign out_pulse_us      = out_us_r;
  assign out_last          = out_last_r;
  assign out_bad_frames    = out_bad_r;

endmodule

@@ tb/tb_top.sv @@
// testbench for the ppm frame decoder: directed table then random frames, checked by a predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ppmfd_pkg::*;

  localparam int MAX_CHANNELS    = MAX_CHANNELS_DEF;
  localparam int SETTLE_CYCLES   = 48;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 7;
  localparam int N_DIRECTED      = 29;

  // one channel value as seen on the result side
  typedef struct packed {
    logic [CHIDX_W-1:0] chan;
    logic [US_W-1:0]    us;
    logic               last;
    logic [BAD_W-1:0]   bad;
  } chan_result_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     reg_idx;
    logic [CFG_DAT_W-1:0]     value;
    logic [TICKS_W-1:0]       ticks;
    bit                       typed;
    chan_result_t             want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TICKS_W-1:0]   in_capture_ticks = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CHIDX_W-1:0]   out_channel_index;
  logic [US_W-1:0]      out_pulse_us;
  logic                 out_last;
  logic [BAD_W-1:0]     out_bad_frames;

  // predictor copy of the registers and the frame state
  logic [DIV_W-1:0] set_ticks    = TICKS_PER_US_RST;
  logic [US_W-1:0]  set_sync     = SYNC_MIN_US_RST;
  logic [US_W-1:0]  set_pulse    = PULSE_MIN_US_RST;
  logic [FCH_W-1:0] set_channels = FRAME_CHANNELS_RST;
  logic [US_W-1:0]  held_us [MAX_CHANNELS];
  int unsigned      held_count = 0;
  bit               dropped = 1'b0;
  logic [BAD_W-1:0] bad_count = '0;

  chan_result_t expected_channels [$];
  chan_result_t head;
  chan_result_t seen;
  int           mismatch_count = 0;
  int           items_sent = 0;
  int           cycle_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;

  // directed requests: reset settings first, then divisor and channel count corners
  dir_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'd0,          1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'd88199,      1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'd88200,      1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'd100000,     1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'd126000,     1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'd168000,     1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'd209999,     1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'd150000,     1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'd95000,      1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'd199500,     1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'd210000,     1'b0, '0},
    // nine pulses overrun the buffer, frame counts as bad
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'd92400,      1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'd92400,      1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'd109200,     1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'd126000,     1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'd142800,     1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'd159600,     1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'd176400,     1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'd193200,     1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'd201600,     1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'hFFFF_FFFF,  1'b0, '0},
    // divisor of zero behaves as one, one channel per frame
    '{ROW_CFG,  REG_TICKS_PER_US,   16'hFF00, 32'd0,     1'b0, '0},
    '{ROW_CFG,  REG_FRAME_CHANNELS, 16'hFFF1, 32'd0,     1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'hFFFF_FFFF,  1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'h0001_0400,  1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'h0001_07D0,  1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'd2500,       1'b1,
      '{3'd0, 16'd2000, 1'b1, 32'd2}},
    // zero channels: an empty frame is good and sends nothing
    '{ROW_CFG,  REG_FRAME_CHANNELS, 16'h0000, 32'd0,     1'b0, '0},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, 32'd2500,       1'b0, '0}
  };

  ppm_frame_decoder DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_capture_ticks  (in_capture_ticks),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_channel_index (out_channel_index),
    .out_pulse_us      (out_pulse_us),
    .out_last          (out_last),
    .out_bad_frames    (out_bad_frames)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // frame decode of one captured interval, updating the predictor state
  task automatic decode_interval(input logic [TICKS_W-1:0] ticks, ref chan_result_t res[$]);
    logic [TICKS_W-1:0] div;
    logic [US_W-1:0]    us;
    chan_result_t       r;
    res.delete();
    div = (set_ticks == '0) ? 32'd1 : TICKS_W'(set_ticks);
    us  = US_W'(ticks / div);
    if (us >= set_sync) begin
      if (!dropped && held_count == set_channels && held_count <= MAX_CHANNELS &&
          held_count <= RESULT_LIMIT) begin
        for (int k = 0; k < held_count; k++) begin
          r.chan = CHIDX_W'(k);
          r.us   = held_us[k];
          r.last = (k + 1 == held_count);
          r.bad  = bad_count;
          res.push_back(r);
        end
      end else begin
        bad_count = bad_count + 1'b1;
      end
      held_count = 0;
      dropped    = 1'b0;
    end else if (us >= set_pulse) begin
      if (held_count < MAX_CHANNELS) begin
        held_us[held_count] = us;
        held_count++;
      end else begin
        dropped = 1'b1;
      end
    end
  endtask

  // one request on the input side, with optional idle gap before it
  task automatic send_interval(input logic [TICKS_W-1:0] ticks, input bit typed,
                               input chan_result_t want);
    chan_result_t res [$];
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do begin
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid         <= 1'b1;
    in_capture_ticks <= ticks;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_interval(ticks, res);
    if (typed) begin
      expected_channels.push_back(want);
    end else begin
      foreach (res[i]) expected_channels.push_back(res[i]);
    end
    items_sent++;
  endtask

  // let the block finish everything before touching the registers
  task automatic drain_block();
    in_valid <= 1'b0;
    while (expected_channels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TICKS_PER_US:   set_ticks    = data[DIV_W-1:0];
      REG_SYNC_MIN_US:    set_sync     = data[US_W-1:0];
      REG_PULSE_MIN_US:   set_pulse    = data[US_W-1:0];
      REG_FRAME_CHANNELS: set_channels = data[FCH_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // all four registers, with junk above the narrow fields
  task automatic load_settings(input int unsigned t, input int unsigned s,
                               input int unsigned q, input int unsigned f);
    logic [31:0] junk;
    junk = $urandom;
    drain_block();
    write_reg(REG_TICKS_PER_US,   {junk[7:0], 8'(t)});
    write_reg(REG_SYNC_MIN_US,    16'(s));
    write_reg(REG_PULSE_MIN_US,   16'(q));
    write_reg(REG_FRAME_CHANNELS, {junk[19:8], 4'(f)});
  endtask

  function automatic logic [TICKS_W-1:0] ticks_for_us(input int unsigned us,
                                                      input int unsigned div);
    return TICKS_W'(us * div + $urandom_range(0, div - 1));
  endfunction

  // one frame: mostly the right pulse count, sometimes off by one or overrun, or only random intervals
  task automatic send_frame();
    int unsigned div;
    int unsigned low_thr;
    int unsigned n;
    int unsigned kind;
    div     = (set_ticks == '0) ? 1 : set_ticks;
    low_thr = (set_pulse < set_sync) ? set_pulse : set_sync;
    kind    = $urandom_range(0, 9);
    n = (set_channels >= 1 && set_channels <= MAX_CHANNELS) ? set_channels
                                                           : $urandom_range(0, MAX_CHANNELS);
    if (kind == 7) n = (n == 0) ? 1 : n - 1 + 2 * $urandom_range(0, 1);
    else if (kind == 8) n = MAX_CHANNELS + $urandom_range(1, 2);
    if (kind == 9) begin
      repeat ($urandom_range(1, 4)) send_interval($urandom, 1'b0, '0);
    end else begin
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 5) == 0)
          send_interval((low_thr == 0) ? $urandom
                                       : ticks_for_us($urandom_range(0, low_thr - 1), div),
                        1'b0, '0);
        if (set_pulse < set_sync)
          send_interval(ticks_for_us($urandom_range(set_pulse, set_sync - 1), div), 1'b0, '0);
      end
      send_interval(($urandom_range(0, 7) == 0) ? $urandom
                    : ticks_for_us($urandom_range(set_sync, 16'hFFFF), div),
                    1'b0, '0);
    end
  endtask

  task automatic note_mismatch(input string what, input chan_result_t want,
                               input chan_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: expected ch %0d us %0d last %0d bad %0d, got ch %0d us %0d last %0d bad %0d",
               what, want.chan, want.us, want.last, want.bad,
               got.chan, got.us, got.last, got.bad);
  endtask

  // result side: random stall, compare each accepted result with the oldest expected
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen = {out_channel_index, out_pulse_us, out_last, out_bad_frames};
      if (expected_channels.size() == 0) begin
        note_mismatch("result with none expected", '0, seen);
      end else begin
        head = expected_channels.pop_front();
        if (head.chan !== seen.chan || head.us !== seen.us || head.last !== seen.last ||
            head.bad !== seen.bad)
          note_mismatch("result mismatch", head, seen);
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // main sequence
  initial begin
    int unsigned t, s, q, f;
    int          phase_start;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        drain_block();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        send_interval(directed_rows[i].ticks, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // random frames over several settings and idle patterns
    for (int p = 0; p < N_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      case (p)
        0: begin t = 255; s = 65535; q = 0;     f = 8;  end
        1: begin t = 1;   s = 0;     q = 65535; f = 15; end
        default: begin
          t = $urandom_range(1, 255);
          q = $urandom_range(0, 3000);
          s = q + $urandom_range(1, 3000);
          f = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
        end
      endcase
      load_settings(t, s, q, f);
      phase_start = items_sent;
      while (items_sent - phase_start < ITEMS_PER_PHASE) send_frame();
    end

    drain_block();
    if (expected_channels.size() != 0)
      $display("%0d expected results never arrived", expected_channels.size());
    if (mismatch_count == 0 && expected_channels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
